>>> rtl/rtpl_pkg.sv
// Package for the route table prefix lookup: sizes, entry and token types.
package rtpl_pkg;

    localparam int MAX_ROUTES   = 32;
    localparam int IDX_W        = $clog2(MAX_ROUTES);
    localparam int CNT_W        = 6;
    localparam int ENTRY_IDX_W  = 5;
    localparam int LIM_W        = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
    localparam logic [31:0] NO_MASK  = 32'h0000_0000;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    typedef struct packed {
        logic [31:0] prefix;
        logic [31:0] mask;
        logic        dynamic;
        logic [31:0] gateway;
        logic [31:0] source_ip;
    } entry_t;

    // Lookup token walking the cell chain, carrying the best match so far.
    typedef struct packed {
        logic             valid;
        logic [31:0]      dest;
        logic [LIM_W-1:0] limit;
        logic             done;
        logic [31:0]      best_mask;
        logic [IDX_W-1:0] best_slot;
        logic [31:0]      best_prefix;
        logic [31:0]      best_hop;
        logic [31:0]      best_src;
    } token_t;

    typedef struct packed {
        logic                   found;
        logic [ENTRY_IDX_W-1:0] route_index;
        logic [31:0]            source_ip;
        logic [31:0]            next_ip;
    } result_t;

endpackage

>>> rtl/route_table_prefix_lookup_top.sv
// Top level of the route table prefix lookup: cell chain, result staging, handshakes.
//
// Input channel s_*: one transfer is either a table write (s_func = 0) or a
// lookup (s_func = 1). A write stores its entry at once and returns an
// all-zero result. A lookup token enters a chain of MAX_ROUTES cells,
// one cell per cycle; each cell holds one route and updates the best
// match. From the last cell the result passes through the holding stage
// and the output register to m_*. One item is in flight at a time: a new
// transfer is taken only once the previous one has left the chain and
// the holding stage.
// Configuration: cfg_data writes route_count (always ready); write it only
// while the block is idle. Counts above MAX_ROUTES saturate.
// Result channel m_*: a holding stage sits before the output register, so
// the next item is taken while a result waits on a stalled receiver.
// Reset (aresetn low, synchronous) empties the chain and both result
// stages and clears route_count; table contents are left as they were.
module route_table_prefix_lookup_top
    import rtpl_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CNT_W-1:0]       cfg_data,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_func,
    input  logic [ENTRY_IDX_W-1:0] s_entry_index,
    input  logic [31:0]            s_dest_address,
    input  logic [31:0]            s_entry_prefix,
    input  logic [31:0]            s_entry_mask,
    input  logic                   s_entry_dynamic,
    input  logic [31:0]            s_entry_next_hop,
    input  logic [31:0]            s_entry_source_ip,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_found,
    output logic [ENTRY_IDX_W-1:0] m_route_index,
    output logic [31:0]            m_source_ip,
    output logic [31:0]            m_next_ip
);

    logic [CNT_W-1:0]      route_count_reg;
    logic                  busy_reg;
    logic                  busy_next;
    logic                  pend_valid_reg;
    logic                  pend_valid_next;
    result_t               pend_reg;
    result_t               pend_next;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    result_t               out_reg;
    result_t               out_next;
    logic                  s_xfer;
    logic                  move;
    logic [LIM_W-1:0]      limit;
    entry_t                wr_entry;
    token_t                tok [MAX_ROUTES+1];
    logic [MAX_ROUTES-1:0] tok_valid;
    result_t               exit_res;

    assign cfg_ready = 1'b1;
    assign s_ready   = !busy_reg && !pend_valid_reg;
    assign s_xfer    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            route_count_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            route_count_reg <= cfg_data;
        end
    end

    assign limit = (LIM_W'(route_count_reg) > LIM_W'(MAX_ROUTES))
                   ? LIM_W'(MAX_ROUTES) : LIM_W'(route_count_reg);

    assign wr_entry = '{prefix:    s_entry_prefix,
                        mask:      s_entry_mask,
                        dynamic:   s_entry_dynamic,
                        gateway:   s_entry_next_hop,
                        source_ip: s_entry_source_ip};

    always_comb begin
        tok[0]             = '0;
        tok[0].valid       = s_xfer && (s_func == FUNC_LOOKUP);
        tok[0].dest        = s_dest_address;
        tok[0].limit       = limit;
        tok[0].best_mask   = NO_MASK;
    end

    for (genvar g = 0; g < MAX_ROUTES; g++) begin : g_cell
        rtpl_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (IDX_W'(g)),
            .wr_en    (s_xfer && (s_func == FUNC_WRITE)),
            .wr_index (s_entry_index),
            .wr_entry (wr_entry),
            .tok_in   (tok[g]),
            .tok_out  (tok[g+1])
        );
        assign tok_valid[g] = tok[g+1].valid;
    end

    always_comb begin
        exit_res = '0;
        if (tok[MAX_ROUTES].best_mask != NO_MASK) begin
            exit_res.found       = 1'b1;
            exit_res.route_index = ENTRY_IDX_W'(tok[MAX_ROUTES].best_slot);
            exit_res.source_ip   = tok[MAX_ROUTES].best_src;
            exit_res.next_ip     = (tok[MAX_ROUTES].best_hop == 32'd0)
                                   ? (tok[MAX_ROUTES].best_prefix | tok[MAX_ROUTES].dest)
                                   : tok[MAX_ROUTES].best_hop;
        end
    end

    assign move = pend_valid_reg && (!m_valid_reg || m_ready);

    always_comb begin
        busy_next       = busy_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg;
        out_next        = out_reg;
        if (tok[0].valid) begin
            busy_next = 1'b1;
        end
        if (tok[MAX_ROUTES].valid) begin
            busy_next       = 1'b0;
            pend_valid_next = 1'b1;
            pend_next       = exit_res;
        end
        if (s_xfer && (s_func == FUNC_WRITE)) begin
            pend_valid_next = 1'b1;
            pend_next       = '0;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (move) begin
            pend_valid_next = 1'b0;
            m_valid_next    = 1'b1;
            out_next        = pend_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            busy_reg       <= busy_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_found       = out_reg.found;
    assign m_route_index = out_reg.route_index;
    assign m_source_ip   = out_reg.source_ip;
    assign m_next_ip     = out_reg.next_ip;

    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(tok_valid) <= 1)
        else $error("more than one lookup token in the chain");

    a_exit_pend_free: assert property (@(posedge aclk) disable iff (!aresetn)
        tok[MAX_ROUTES].valid |-> !pend_valid_reg)
        else $error("chain result arrived while holding stage full");

    a_busy_tracks_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        (tok_valid != '0) |-> busy_reg)
        else $error("token in chain while block not busy");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |-> (m_route_index == '0 && m_source_ip == '0
                                   && m_next_ip == '0))
        else $error("result without a route carries nonzero fields");

endmodule

>>> rtl/rtpl_cell.sv
// One table cell: holds a route and evaluates the passing lookup token against it.
module rtpl_cell
    import rtpl_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [IDX_W-1:0]       cell_idx,
    input  logic                   wr_en,
    input  logic [ENTRY_IDX_W-1:0] wr_index,
    input  entry_t                 wr_entry,
    input  token_t                 tok_in,
    output token_t                 tok_out
);

    entry_t      entry_reg;
    token_t      tok_reg;
    token_t      tok_next;
    logic [31:0] agree;
    logic        active;
    logic        take;

    always_ff @(posedge aclk) begin
        if (wr_en && (LIM_W'(wr_index) == LIM_W'(cell_idx))) begin
            entry_reg <= wr_entry;
        end
    end

    always_comb begin
        agree    = ~(tok_in.dest ^ entry_reg.prefix) & entry_reg.mask;
        active   = tok_in.valid && !tok_in.done && (LIM_W'(cell_idx) < tok_in.limit);
        take     = active && (agree == entry_reg.mask)
                   && (entry_reg.dynamic || (agree > tok_in.best_mask));
        tok_next = tok_in;
        if (take) begin
            tok_next.best_mask   = agree;
            tok_next.best_slot   = cell_idx;
            tok_next.best_prefix = entry_reg.prefix;
            tok_next.best_hop    = entry_reg.gateway;
            tok_next.best_src    = entry_reg.source_ip;
            tok_next.done        = entry_reg.dynamic && (agree == ALL_ONES);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

>>> verif/tb_route_table_prefix_lookup_top.sv
// Self-checking testbench for the route table prefix lookup: directed and random traffic.
module tb_route_table_prefix_lookup_top
    import rtpl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                   func;
        logic [ENTRY_IDX_W-1:0] entry_index;
        logic [31:0]            dest;
        logic [31:0]            prefix;
        logic [31:0]            mask;
        logic                   dynamic;
        logic [31:0]            gateway;
        logic [31:0]            source_ip;
    } route_req_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CNT_W-1:0]       cfg_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic                   s_func = 1'b0;
    logic [ENTRY_IDX_W-1:0] s_entry_index = '0;
    logic [31:0]            s_dest_address = '0;
    logic [31:0]            s_entry_prefix = '0;
    logic [31:0]            s_entry_mask = '0;
    logic                   s_entry_dynamic = 1'b0;
    logic [31:0]            s_entry_next_hop = '0;
    logic [31:0]            s_entry_source_ip = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_found;
    logic [ENTRY_IDX_W-1:0] m_route_index;
    logic [31:0]            m_source_ip;
    logic [31:0]            m_next_ip;

    route_table_prefix_lookup_top u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_func            (s_func),
        .s_entry_index     (s_entry_index),
        .s_dest_address    (s_dest_address),
        .s_entry_prefix    (s_entry_prefix),
        .s_entry_mask      (s_entry_mask),
        .s_entry_dynamic   (s_entry_dynamic),
        .s_entry_next_hop  (s_entry_next_hop),
        .s_entry_source_ip (s_entry_source_ip),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_found           (m_found),
        .m_route_index     (m_route_index),
        .m_source_ip       (m_source_ip),
        .m_next_ip         (m_next_ip)
    );

    // shadow route table, updated when a transfer is accepted
    logic [31:0]      rt_prefix   [MAX_ROUTES];
    logic [31:0]      rt_mask     [MAX_ROUTES];
    logic             rt_dynamic  [MAX_ROUTES];
    logic [31:0]      rt_gateway  [MAX_ROUTES];
    logic [31:0]      rt_source   [MAX_ROUTES];
    logic [CNT_W-1:0] rt_count = '0;

    // table as planned by the stimulus generator, used to aim lookups
    logic [31:0] plan_prefix [MAX_ROUTES];
    logic [31:0] plan_mask   [MAX_ROUTES];
    int          plan_count = 0;

    route_req_t pending_requests[$];
    result_t    expected_routes[$];
    route_req_t drv_req;
    result_t    want;
    int         send_gap = 0;
    int         stall_left = 0;
    int         gap_pct = 20;
    int         error_count = 0;
    int         result_seq = 0;
    int         random_items = 0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #8_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        error_count++;
        if (error_count <= 40)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function automatic result_t predict_route_result(input route_req_t req);
        result_t     res;
        logic [31:0] best_mask;
        logic [4:0]  best_slot;
        int          limit;
        bit          stop;
        res = '0;
        best_mask = NO_MASK;
        best_slot = '0;
        stop = 1'b0;
        if (req.func == FUNC_WRITE) begin
            rt_prefix[req.entry_index]   = req.prefix;
            rt_mask[req.entry_index]     = req.mask;
            rt_dynamic[req.entry_index]  = req.dynamic;
            rt_gateway[req.entry_index]  = req.gateway;
            rt_source[req.entry_index]   = req.source_ip;
            return res;
        end
        limit = (rt_count > MAX_ROUTES) ? MAX_ROUTES : int'(rt_count);
        for (int k = 0; k < limit && !stop; k++) begin
            if (((req.dest ^ rt_prefix[k]) & rt_mask[k]) == 32'h0 &&
                (rt_dynamic[k] || rt_mask[k] > best_mask)) begin
                best_mask = rt_mask[k];
                best_slot = 5'(k);
                stop = rt_dynamic[k] && rt_mask[k] == ALL_ONES;
            end
        end
        if (best_mask != NO_MASK) begin
            res.found       = 1'b1;
            res.route_index = best_slot;
            res.source_ip   = rt_source[best_slot];
            res.next_ip     = (rt_gateway[best_slot] == 32'h0) ?
                              (rt_prefix[best_slot] | req.dest) : rt_gateway[best_slot];
        end
        return res;
    endfunction

    function automatic int draw_gap();
        if ($urandom_range(0, 99) >= gap_pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 60);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [31:0] prefix_mask(input int len);
        return (len == 0) ? NO_MASK : (ALL_ONES << (32 - len));
    endfunction

    task automatic queue_write(input logic [4:0] slot, input logic [31:0] prefix,
                               input logic [31:0] mask, input logic dynamic,
                               input logic [31:0] hop, input logic [31:0] src);
        route_req_t req;
        req.func        = FUNC_WRITE;
        req.entry_index = slot;
        req.dest        = $urandom;
        req.prefix      = prefix;
        req.mask        = mask;
        req.dynamic     = dynamic;
        req.gateway     = hop;
        req.source_ip   = src;
        plan_prefix[slot] = prefix;
        plan_mask[slot]   = mask;
        pending_requests.push_back(req);
    endtask

    task automatic queue_lookup(input logic [31:0] dest);
        route_req_t req;
        req.func        = FUNC_LOOKUP;
        req.entry_index = 5'($urandom);
        req.dest        = dest;
        req.prefix      = $urandom;
        req.mask        = $urandom;
        req.dynamic     = 1'($urandom);
        req.gateway     = $urandom;
        req.source_ip   = $urandom;
        pending_requests.push_back(req);
    endtask

    task automatic queue_random_write(input logic [4:0] slot);
        logic [31:0] mask;
        logic [31:0] prefix;
        logic [31:0] hop;
        mask = ($urandom_range(0, 9) == 0) ? 32'($urandom) : prefix_mask($urandom_range(0, 32));
        prefix = {8'(8'h0A + $urandom_range(0, 3)), 8'($urandom_range(0, 3)), 16'($urandom)};
        if ($urandom_range(0, 19) == 0)
            prefix = $urandom;
        hop = ($urandom_range(0, 9) < 3) ? 32'h0 : 32'($urandom);
        queue_write(slot, prefix, mask, ($urandom_range(0, 3) == 0), hop, $urandom);
    endtask

    task automatic queue_random_lookup();
        int          s;
        logic [31:0] dest;
        if (plan_count > 0 && $urandom_range(0, 9) < 7) begin
            s = $urandom_range(0, plan_count - 1);
            dest = (plan_prefix[s] & plan_mask[s]) | ($urandom & ~plan_mask[s]);
        end else begin
            case ($urandom_range(0, 3))
                0:       dest = $urandom;
                1:       dest = ($urandom_range(0, 1) == 0) ? NO_MASK : ALL_ONES;
                default: dest = {8'(8'h0A + $urandom_range(0, 3)), 24'($urandom)};
            endcase
        end
        queue_lookup(dest);
    endtask

    task automatic drain();
        while (!(pending_requests.size() == 0 && !s_valid && expected_routes.size() == 0))
            @(negedge aclk);
    endtask

    task automatic set_route_count(input logic [CNT_W-1:0] n);
        @(posedge aclk);
        cfg_data  <= n;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        rt_count   = n;
        plan_count = (n > MAX_ROUTES) ? MAX_ROUTES : int'(n);
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready)
                expected_routes.push_back(predict_route_result(drv_req));
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    drv_req = pending_requests.pop_front();
                    s_func            <= drv_req.func;
                    s_entry_index     <= drv_req.entry_index;
                    s_dest_address    <= drv_req.dest;
                    s_entry_prefix    <= drv_req.prefix;
                    s_entry_mask      <= drv_req.mask;
                    s_entry_dynamic   <= drv_req.dynamic;
                    s_entry_next_hop  <= drv_req.gateway;
                    s_entry_source_ip <= drv_req.source_ip;
                    s_valid           <= 1'b1;
                    send_gap = draw_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                result_seq++;
                if (expected_routes.size() == 0) begin
                    flag_mismatch($sformatf("transfer %0d with no result pending", result_seq));
                end else begin
                    want = expected_routes.pop_front();
                    if (m_found !== want.found)
                        flag_mismatch($sformatf("transfer %0d found %0b, want %0b",
                                                result_seq, m_found, want.found));
                    if (m_route_index !== want.route_index)
                        flag_mismatch($sformatf("transfer %0d route_index %0d, want %0d",
                                                result_seq, m_route_index, want.route_index));
                    if (m_source_ip !== want.source_ip)
                        flag_mismatch($sformatf("transfer %0d source_ip %h, want %h",
                                                result_seq, m_source_ip, want.source_ip));
                    if (m_next_ip !== want.next_ip)
                        flag_mismatch($sformatf("transfer %0d next_ip %h, want %h",
                                                result_seq, m_next_ip, want.next_ip));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                stall_left = draw_gap();
            end
        end
    end

    initial begin
        int               phase_len;
        logic [CNT_W-1:0] next_count;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // empty search range: nothing can match
        queue_lookup(32'h0A01_0203);
        // zero-mask dynamic entry first; later entries take over from it
        queue_write(5'd0, ALL_ONES, NO_MASK, 1'b1, ALL_ONES, ALL_ONES);
        queue_write(5'd1, 32'h0A00_0000, prefix_mask(8), 1'b0, 32'h0, 32'h0A00_00FE);
        queue_write(5'd2, 32'h0A01_0000, prefix_mask(16), 1'b0, 32'h0A00_0001, 32'h0A01_00FE);
        queue_write(5'd3, 32'h0A01_0203, ALL_ONES, 1'b1, 32'h0, 32'h0A01_02FE);
        queue_write(5'd4, 32'h0A01_0200, prefix_mask(24), 1'b0, 32'hC0A8_0001, 32'h0);
        queue_write(5'd5, 32'hC0A8_0000, prefix_mask(16), 1'b1, 32'h1111_1111, 32'h2222_2222);
        queue_write(5'd6, 32'hC0A8_0100, prefix_mask(24), 1'b0, 32'h3333_3333, 32'h4444_4444);
        queue_write(5'd7, 32'hC000_0000, prefix_mask(8), 1'b1, 32'h5555_5555, 32'h6666_6666);
        drain();
        set_route_count(6'd8);
        queue_lookup(32'h0A01_0203);
        queue_lookup(32'h0A01_0209);
        queue_lookup(32'h0A01_0909);
        queue_lookup(32'h0A09_0909);
        queue_lookup(32'hC0A8_0105);
        queue_lookup(32'h0B00_0000);
        queue_lookup(ALL_ONES);
        queue_lookup(NO_MASK);
        drain();

        // fill the rest of the table while searching the first eight slots
        gap_pct = 30;
        for (int s = 8; s < MAX_ROUTES; s++) begin
            queue_random_write(5'(s));
            repeat ($urandom_range(0, 3)) queue_random_lookup();
        end
        drain();

        while (random_items < 1130) begin
            case ($urandom_range(0, 5))
                0:       next_count = 6'd0;
                1:       next_count = 6'd32;
                2:       next_count = 6'd63;
                3:       next_count = 6'($urandom_range(33, 62));
                4:       next_count = 6'd1;
                default: next_count = 6'($urandom_range(2, 31));
            endcase
            set_route_count(next_count);
            case ($urandom_range(0, 3))
                0:       gap_pct = 0;
                1:       gap_pct = 10;
                2:       gap_pct = 30;
                default: gap_pct = 60;
            endcase
            phase_len = $urandom_range(20, 120);
            for (int i = 0; i < phase_len; i++) begin
                if ($urandom_range(0, 4) == 0)
                    queue_random_write(5'($urandom));
                else
                    queue_random_lookup();
            end
            random_items += phase_len;
            drain();
        end

        repeat (60) @(posedge aclk);
        if (expected_routes.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", expected_routes.size()));
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/rtpl_pkg.sv
rtl/rtpl_cell.sv
rtl/route_table_prefix_lookup_top.sv
verif/tb_route_table_prefix_lookup_top.sv
